/* rtl/grb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grb_pkg
// Shared types, word map and codes of the GPIO register block.
// ----------------------------------------------------------------------------
package grb_pkg;

  localparam int unsigned NumPinsDef  = 54;
  localparam int unsigned FieldW      = 54;
  localparam int unsigned DataW       = 32;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned PinsPerWord = 10;
  localparam int unsigned NumSelWords = 6;

  // byte offsets of the first word of each group
  localparam logic [7:0] OffSel0 = 8'h00;
  localparam logic [7:0] OffSet0 = 8'h1C;
  localparam logic [7:0] OffClr0 = 8'h28;
  localparam logic [7:0] OffLev0 = 8'h34;
  localparam logic [7:0] OffPull = 8'h94;
  localparam logic [7:0] OffPclk0 = 8'h98;

  localparam logic [IdxW-1:0] WSel0    = OffSel0[7:2];
  localparam logic [IdxW-1:0] WSelLast = WSel0 + IdxW'(NumSelWords - 1);
  localparam logic [IdxW-1:0] WSet0    = OffSet0[7:2];
  localparam logic [IdxW-1:0] WSet1    = WSet0 + IdxW'(1);
  localparam logic [IdxW-1:0] WClr0    = OffClr0[7:2];
  localparam logic [IdxW-1:0] WClr1    = WClr0 + IdxW'(1);
  localparam logic [IdxW-1:0] WLev0    = OffLev0[7:2];
  localparam logic [IdxW-1:0] WLev1    = WLev0 + IdxW'(1);
  localparam logic [IdxW-1:0] WPull    = OffPull[7:2];
  localparam logic [IdxW-1:0] WPclk0   = OffPclk0[7:2];
  localparam logic [IdxW-1:0] WPclk1   = WPclk0 + IdxW'(1);

  localparam logic [2:0] FuncOutput = 3'b001;
  localparam logic [1:0] PullUp     = 2'b10;
  localparam logic [1:0] PullDown   = 2'b01;

  typedef struct packed {
    logic              mode;
    logic [IdxW-1:0]   word_index;
    logic [DataW-1:0]  write_data;
    logic [FieldW-1:0] pad_levels;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0]  read_data;
    logic              unmapped;
    logic [FieldW-1:0] drive_levels;
    logic [FieldW-1:0] drive_enables;
    logic [FieldW-1:0] pull_ups;
    logic [FieldW-1:0] pull_downs;
  } rsp_t;

endpackage

/* rtl/grb_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grb_in_reg
// Input register: holds one access beat until the register file takes it.
// ----------------------------------------------------------------------------
module grb_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  grb_pkg::req_t req_i,
  input  logic          take_i,
  output logic          valid_o,
  output grb_pkg::req_t req_o
);
  import grb_pkg::*;

  logic vld_q, vld_d;
  req_t req_q;

  assign ready_o = !vld_q || take_i;
  assign vld_d   = (valid_i && ready_o) || (vld_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      req_q <= req_i;
    end
  end

  assign valid_o = vld_q;
  assign req_o   = req_q;

endmodule

/* rtl/grb_regfile.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grb_regfile
// Pin state registers and the single-pass access decode and update.
// ----------------------------------------------------------------------------
module grb_regfile #(
  parameter int unsigned NUM_PINS = grb_pkg::NumPinsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  grb_pkg::req_t req_i,
  output grb_pkg::rsp_t rsp_o
);
  import grb_pkg::*;

  localparam logic [63:0] PinMask = {64{1'b1}} >> (64 - NUM_PINS);

  logic [3*NUM_PINS-1:0] func_q, func_d;
  logic [2*NUM_PINS-1:0] pull_q, pull_d;
  logic [NUM_PINS-1:0]   latch_q, latch_d;
  logic [1:0]            pctl_q, pctl_d;

  logic                wr;
  logic                bank_hi;
  logic [63:0]         bank64;
  logic [NUM_PINS-1:0] bank_bits;
  logic [63:0]         pads64;
  logic [DataW-1:0]    rd;
  logic                unm;
  logic [63:0]         en64, up64, dn64, lat64;

  assign wr        = req_i.mode;
  assign bank_hi   = (req_i.word_index == WSet1) || (req_i.word_index == WClr1) ||
                     (req_i.word_index == WLev1) || (req_i.word_index == WPclk1);
  assign bank64    = bank_hi ? {req_i.write_data, 32'h0} : {32'h0, req_i.write_data};
  assign bank_bits = bank64[NUM_PINS-1:0];
  assign pads64    = 64'(req_i.pad_levels) & PinMask;

  always_comb begin
    func_d  = func_q;
    pull_d  = pull_q;
    latch_d = latch_q;
    pctl_d  = pctl_q;
    rd      = '0;
    unm     = 1'b0;
    if (req_i.word_index inside {[WSel0:WSelLast]}) begin
      for (int s = 0; s < NumSelWords; s++) begin
        for (int k = 0; k < PinsPerWord; k++) begin
          if ((s * PinsPerWord + k < NUM_PINS) && (req_i.word_index == WSel0 + IdxW'(s))) begin
            if (wr) begin
              func_d[3*(s*PinsPerWord+k) +: 3] = req_i.write_data[3*k +: 3];
            end else begin
              rd[3*k +: 3] = func_q[3*(s*PinsPerWord+k) +: 3];
            end
          end
        end
      end
    end else begin
      case (req_i.word_index)
        WSet0, WSet1: begin
          if (wr) latch_d = latch_q | bank_bits;
        end
        WClr0, WClr1: begin
          if (wr) latch_d = latch_q & ~bank_bits;
        end
        WLev0, WLev1: begin
          if (!wr) rd = bank_hi ? pads64[63:32] : pads64[31:0];
        end
        WPull: begin
          if (wr) begin
            pctl_d = req_i.write_data[1:0];
          end else begin
            rd = {30'h0, pctl_q};
          end
        end
        WPclk0, WPclk1: begin
          if (wr) begin
            for (int p = 0; p < NUM_PINS; p++) begin
              if (bank_bits[p]) pull_d[2*p +: 2] = pctl_q;
            end
          end
        end
        default: begin
          unm = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    en64 = '0;
    up64 = '0;
    dn64 = '0;
    for (int p = 0; p < NUM_PINS; p++) begin
      en64[p] = (func_d[3*p +: 3] == FuncOutput);
      up64[p] = (pull_d[2*p +: 2] == PullUp);
      dn64[p] = (pull_d[2*p +: 2] == PullDown);
    end
  end

  assign lat64 = 64'(latch_d);

  always_comb begin
    rsp_o.read_data     = rd;
    rsp_o.unmapped      = unm;
    rsp_o.drive_levels  = lat64[FieldW-1:0];
    rsp_o.drive_enables = en64[FieldW-1:0];
    rsp_o.pull_ups      = up64[FieldW-1:0];
    rsp_o.pull_downs    = dn64[FieldW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q  <= '0;
      pull_q  <= '0;
      latch_q <= '0;
      pctl_q  <= '0;
    end else if (en_i) begin
      func_q  <= func_d;
      pull_q  <= pull_d;
      latch_q <= latch_d;
      pctl_q  <= pctl_d;
    end
  end

endmodule

/* rtl/grb_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grb_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module grb_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  grb_pkg::rsp_t rsp_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          ready_i,
  output grb_pkg::rsp_t rsp_o
);
  import grb_pkg::*;

  logic vld_q, vld_d;
  rsp_t rsp_q;

  assign ready_o = !vld_q || ready_i;
  assign vld_d   = load_i || (vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign valid_o = vld_q;
  assign rsp_o   = rsp_q;

endmodule

/* rtl/gpio_register_block.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_register_block
// Pin controller with function select, output latch and pull control.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one register access per beat. tuser carries mode (1 = write),
//   tdata carries word_index, write_data and the current pad levels.
//   Master stream: one result beat per access: read_data, the drive, enable
//   and pull vectors as they stand after the access, and unmapped on tuser.
//   Path: an accepted beat waits in the input register until the result
//   register can take it. Throughput: one access per cycle unless the
//   receiver stalls; the input register, the decode and update logic and
//   the result register form a two-stage chain, with all state updated in
//   the same cycle an access moves into the result register.
//   Reset: all pins are inputs with no pull, the output latch and pull
//   control word are zero, both streams are empty.
//   Receiver stall: the result register holds its beat; one more access
//   waits in the input register, then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module gpio_register_block #(
  parameter int unsigned NUM_PINS = grb_pkg::NumPinsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [95:0]  s_axis_tdata_i,   // word_index, write_data, pad_levels, pad
  input  logic [0:0]   s_axis_tuser_i,   // mode
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [247:0] m_axis_tdata_o,   // read_data, drive_levels, drive_enables,
                                         // pull_ups, pull_downs
  output logic [0:0]   m_axis_tuser_o    // unmapped
);
  import grb_pkg::*;

  req_t in_req, stg_req;
  rsp_t upd_rsp, out_rsp;
  logic stg_vld, out_rdy, adv;

  always_comb begin
    in_req.mode       = s_axis_tuser_i[0];
    in_req.word_index = s_axis_tdata_i[5:0];
    in_req.write_data = s_axis_tdata_i[37:6];
    in_req.pad_levels = s_axis_tdata_i[91:38];
  end

  assign adv = stg_vld && out_rdy;

  grb_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .req_i   (in_req),
    .take_i  (adv),
    .valid_o (stg_vld),
    .req_o   (stg_req)
  );

  grb_regfile #(
    .NUM_PINS (NUM_PINS)
  ) u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .req_i  (stg_req),
    .rsp_o  (upd_rsp)
  );

  grb_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .rsp_i   (upd_rsp),
    .ready_o (out_rdy),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .rsp_o   (out_rsp)
  );

  assign m_axis_tdata_o = {out_rsp.pull_downs, out_rsp.pull_ups, out_rsp.drive_enables,
                           out_rsp.drive_levels, out_rsp.read_data};
  assign m_axis_tuser_o = out_rsp.unmapped;

endmodule

/* rtl/grb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grb_checker
// Port-level assertions for the GPIO register block, bound to the top level.
// ----------------------------------------------------------------------------
module grb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_tvalid_i,
  input logic         s_tready_i,
  input logic         m_tvalid_i,
  input logic         m_tready_i,
  input logic [247:0] m_tdata_i,
  input logic [0:0]   m_tuser_i
);

  // result side empty means the input side can always take a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_i |-> s_tready_i)
    else $error("input stalled while result side empty");

  // accepted beat into an empty result side shows up after both registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i && !m_tvalid_i |=> ##1 m_tvalid_i)
    else $error("result beat missing after accept");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i[0] |-> m_tdata_i[31:0] == 32'h0)
    else $error("unmapped access returned read data");

  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_tvalid_i)
    else $error("result valid out of reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("stalled result beat changed");

endmodule

bind gpio_register_block grb_checker u_grb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);
